@@ rtl/marker_delimited_frame_receiver_defines.svh @@
// Assertion helpers for the frame receiver.
`ifndef MARKER_DELIMITED_FRAME_RECEIVER_DEFINES_SVH
`define MARKER_DELIMITED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define MDFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, off during reset.
`define MDFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

@@ rtl/mdfr_pkg.sv @@
package mdfr_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 64;

  localparam int MARKER_W = 16;
  localparam int BYTE_W = 8;
  localparam int MAXPAY_W = 7;
  localparam int INDEX_W = 6;
  localparam int LENGTH_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [MARKER_W-1:0] RESET_START_MARKER = 16'h12BC;
  localparam logic [MARKER_W-1:0] RESET_END_MARKER = 16'h34DE;
  localparam logic [MAXPAY_W-1:0] RESET_MAX_PAYLOAD = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  // Strobes from the sequencer to the payload store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

@@ rtl/mdfr_in_if.sv @@
interface mdfr_in_if;
  logic                           valid;
  logic                           ready;
  logic [mdfr_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/mdfr_out_if.sv @@
interface mdfr_out_if;
  logic                           valid;
  logic                           ready;
  logic [mdfr_pkg::BYTE_W-1:0]    payload_byte;
  logic [mdfr_pkg::INDEX_W-1:0]   byte_index;
  logic [mdfr_pkg::LENGTH_W-1:0]  payload_length;
  logic                           last_byte;

  modport source (output valid, output payload_byte, output byte_index,
                  output payload_length, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input byte_index,
                input payload_length, input last_byte, output ready);
endinterface

@@ rtl/mdfr_match.sv @@
// Shared shift-and-compare unit: serves the start window while idle and the
// end window inside a frame.
module mdfr_match (
  input  logic [mdfr_pkg::MARKER_W-1:0] window,
  input  logic [mdfr_pkg::BYTE_W-1:0]   data,
  input  logic [mdfr_pkg::MARKER_W-1:0] marker,
  output logic [mdfr_pkg::MARKER_W-1:0] window_next,
  output logic                          hit
);

  assign window_next = {window[mdfr_pkg::MARKER_W-mdfr_pkg::BYTE_W-1:0], data};
  assign hit = (window_next == marker);

endmodule

@@ rtl/mdfr_store.sv @@
module mdfr_store #(
  parameter int BUFFER_DEPTH = mdfr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  mdfr_pkg::store_ctl_t        ctl,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  logic [mdfr_pkg::BYTE_W-1:0] wr_data,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output logic [mdfr_pkg::BYTE_W-1:0] rd_data
);

  logic [mdfr_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/marker_delimited_frame_receiver.sv @@
// Marker-delimited frame receiver.
// rx carries one received byte per beat. While idle the last two bytes are
// matched against start_marker; inside a frame bytes are stored and the last
// two are matched against end_marker. On the end match the stored payload,
// less the first end-marker byte, leaves on res one beat per byte in order,
// last_byte set on the final beat. An empty frame gives a single zero beat
// with payload_length 0. A byte that would exceed the size limit drops the
// frame with no output.
// Each byte is accepted, then makes one pass through the shared window
// compare unit. A closing byte then starts the readout: each payload beat is
// a registered memory read, then the output beat. rx is not ready while a
// byte is checked or the readout runs; a stall on res simply holds the
// current beat. Reset returns the block to idle, clears the windows and loads
// the marker and limit registers with their defaults; the store needs no
// clearing. cfg_we writes a register in the same edge; index 3 is ignored.
module marker_delimited_frame_receiver #(
  parameter int BUFFER_DEPTH = mdfr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mdfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdfr_pkg::MARKER_W-1:0]    cfg_data,
  mdfr_in_if.sink                          rx,
  mdfr_out_if.source                       res
);

  `include "marker_delimited_frame_receiver_defines.svh"

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int LW = (CW > mdfr_pkg::MAXPAY_W) ? CW : mdfr_pkg::MAXPAY_W;

  localparam logic [1:0] S_RX  = 2'd0;
  localparam logic [1:0] S_CHK = 2'd1;
  localparam logic [1:0] S_RD  = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0]                     state;
  logic [mdfr_pkg::MARKER_W-1:0]  start_marker;
  logic [mdfr_pkg::MARKER_W-1:0]  end_marker;
  logic [mdfr_pkg::MAXPAY_W-1:0]  max_payload;
  logic [mdfr_pkg::MARKER_W-1:0]  start_window;
  logic [mdfr_pkg::MARKER_W-1:0]  end_window;
  logic                           in_frame;
  logic [CW-1:0]                  byte_count;
  logic [CW-1:0]                  frame_len;
  logic [AW-1:0]                  rd_idx;
  logic                           empty_frame;
  logic [mdfr_pkg::BYTE_W-1:0]    rx_data;

  logic [mdfr_pkg::MARKER_W-1:0]  sel_window;
  logic [mdfr_pkg::MARKER_W-1:0]  sel_marker;
  logic [mdfr_pkg::MARKER_W-1:0]  window_next;
  logic                           hit;
  logic                           limit_hit;
  logic [CW-1:0]                  len_next;
  logic                           last;
  logic [mdfr_pkg::BYTE_W-1:0]    rd_data;
  mdfr_pkg::store_ctl_t           store_ctl;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= mdfr_pkg::RESET_START_MARKER;
      end_marker <= mdfr_pkg::RESET_END_MARKER;
      max_payload <= mdfr_pkg::RESET_MAX_PAYLOAD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdfr_pkg::CFG_START_MARKER: start_marker <= cfg_data;
        mdfr_pkg::CFG_END_MARKER: end_marker <= cfg_data;
        mdfr_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data[mdfr_pkg::MAXPAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign sel_window = in_frame ? end_window : start_window;
  assign sel_marker = in_frame ? end_marker : start_marker;

  mdfr_match u_match (
    .window      (sel_window),
    .data        (rx_data),
    .marker      (sel_marker),
    .window_next (window_next),
    .hit         (hit)
  );

  assign limit_hit = (LW'(byte_count) >= LW'(max_payload))
                  || (byte_count == CW'(BUFFER_DEPTH));
  // The byte stored just before the closing byte is the first end-marker byte.
  assign len_next = (byte_count > CW'(1)) ? byte_count - CW'(1) : '0;
  assign last = empty_frame || ((CW'(rd_idx) + CW'(1)) == frame_len);

  assign store_ctl.wr_en = (state == S_CHK) && in_frame && !hit && !limit_hit;
  assign store_ctl.rd_en = (state == S_RD);

  mdfr_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (rx_data),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RX;
      in_frame <= 1'b0;
      start_window <= '0;
      end_window <= '0;
      byte_count <= '0;
    end else begin
      unique case (state)
        S_RX: begin
          if (rx.valid) begin
            rx_data <= rx.rx_byte;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= S_RX;
          if (!in_frame) begin
            start_window <= window_next;
            if (hit) begin
              in_frame <= 1'b1;
              byte_count <= '0;
            end
          end else begin
            end_window <= window_next;
            if (hit) begin
              in_frame <= 1'b0;
              frame_len <= len_next;
              rd_idx <= '0;
              if (len_next == '0) begin
                empty_frame <= 1'b1;
                state <= S_OUT;
              end else begin
                empty_frame <= 1'b0;
                state <= S_RD;
              end
            end else if (limit_hit) begin
              in_frame <= 1'b0;
            end else begin
              byte_count <= byte_count + CW'(1);
            end
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            if (last) begin
              state <= S_RX;
            end else begin
              rd_idx <= rd_idx + AW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_RX;
      endcase
    end
  end

  assign rx.ready = (state == S_RX);
  assign res.valid = (state == S_OUT);
  assign res.payload_byte = empty_frame ? '0 : rd_data;
  assign res.byte_index = mdfr_pkg::INDEX_W'(rd_idx);
  assign res.payload_length = mdfr_pkg::LENGTH_W'(frame_len);
  assign res.last_byte = last;

  `MDFR_ASSERT_NOW(a_one_side, rx.ready, !res.valid)
  `MDFR_ASSERT_NEXT(a_last_to_idle, res.valid && res.ready && res.last_byte, rx.ready)
  `MDFR_ASSERT_NOW(a_count_bound, store_ctl.wr_en, byte_count < CW'(BUFFER_DEPTH))
  `MDFR_ASSERT_NEXT(a_close_leaves_frame, state == S_CHK && in_frame && hit, !in_frame)

endmodule

@@ tb/tb_marker_delimited_frame_receiver.sv @@
module tb_marker_delimited_frame_receiver;

  // unmapped index, write is dropped
  localparam logic [mdfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PHASE_BYTES = 50;

  typedef struct packed {
    logic [mdfr_pkg::BYTE_W-1:0]   payload;
    logic [mdfr_pkg::INDEX_W-1:0]  pos;
    logic [mdfr_pkg::LENGTH_W-1:0] len;
    logic                          last;
  } frame_beat_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [mdfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mdfr_pkg::MARKER_W-1:0]  cfg_data;

  mdfr_in_if  rx();
  mdfr_out_if res();

  marker_delimited_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .res       (res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver model state
  logic [mdfr_pkg::MARKER_W-1:0] start_marker_q;
  logic [mdfr_pkg::MARKER_W-1:0] end_marker_q;
  logic [mdfr_pkg::MAXPAY_W-1:0] max_payload_q;
  logic [15:0]                   scan_win;
  logic [15:0]                   tail_win;
  logic                          in_frame_m;
  int unsigned                   stored_cnt;
  logic [mdfr_pkg::BYTE_W-1:0]   payload_mem [mdfr_pkg::BUFFER_DEPTH_DEFAULT];

  frame_beat_t pending_beats[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  bit          throttle_en = 1'b1;

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!throttle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic predict_rx_byte(input logic [mdfr_pkg::BYTE_W-1:0] b);
    int unsigned plen, lim;
    if (!in_frame_m) begin
      scan_win = {scan_win[7:0], b};
      if (scan_win == start_marker_q) begin
        in_frame_m = 1'b1;
        stored_cnt = 0;
      end
    end else begin
      tail_win = {tail_win[7:0], b};
      if (tail_win == end_marker_q) begin
        in_frame_m = 1'b0;
        // first end-marker byte was stored, drop it
        plen = (stored_cnt > 0) ? stored_cnt - 1 : 0;
        if (plen == 0)
          pending_beats.push_back('{payload: '0, pos: '0, len: '0, last: 1'b1});
        else
          for (int unsigned i = 0; i < plen; i++)
            pending_beats.push_back('{payload: payload_mem[i],
                                      pos: mdfr_pkg::INDEX_W'(i),
                                      len: mdfr_pkg::LENGTH_W'(plen),
                                      last: (i + 1 == plen)});
      end else begin
        lim = (max_payload_q > mdfr_pkg::BUFFER_DEPTH_DEFAULT) ?
              mdfr_pkg::BUFFER_DEPTH_DEFAULT : max_payload_q;
        if (stored_cnt >= lim) begin
          in_frame_m = 1'b0;
        end else begin
          payload_mem[stored_cnt] = b;
          stored_cnt++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : beat_check
    frame_beat_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_beats.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: payload %0h index %0d length %0d last %0b",
                   res.payload_byte, res.byte_index, res.payload_length, res.last_byte);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("payload_byte", want.payload, res.payload_byte);
        check_field("byte_index", 8'(want.pos), 8'(res.byte_index));
        check_field("payload_length", 8'(want.len), 8'(res.payload_length));
        check_field("last_byte", 8'(want.last), 8'(res.last_byte));
      end
    end
  end

  // res backpressure
  initial begin : res_stall
    int unsigned hold;
    hold = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = idle_gap();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_marker_delimited_frame_receiver NOT OK");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [mdfr_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    predict_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
    gap = idle_gap();
    if (gap != 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait until the block has drained everything in flight
  task automatic settle();
    rx.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [mdfr_pkg::MARKER_W-1:0] sm,
                             input logic [mdfr_pkg::MARKER_W-1:0] em,
                             input logic [mdfr_pkg::MAXPAY_W-1:0] maxp);
    cfg_we <= 1'b1;
    cfg_index <= mdfr_pkg::CFG_START_MARKER;
    cfg_data <= sm;
    @(negedge clk);
    cfg_index <= mdfr_pkg::CFG_END_MARKER;
    cfg_data <= em;
    @(negedge clk);
    cfg_index <= mdfr_pkg::CFG_MAX_PAYLOAD;
    cfg_data <= mdfr_pkg::MARKER_W'(maxp);
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data <= mdfr_pkg::MARKER_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    start_marker_q = sm;
    end_marker_q = em;
    max_payload_q = maxp;
  endtask

  task automatic send_frame();
    int unsigned lim, kind, plen, noise;
    lim = (max_payload_q > mdfr_pkg::BUFFER_DEPTH_DEFAULT) ?
          mdfr_pkg::BUFFER_DEPTH_DEFAULT : max_payload_q;
    kind = $urandom_range(0, 99);
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    throttle_en = ($urandom_range(0, 4) != 0);
    repeat (noise) send_byte(mdfr_pkg::BYTE_W'($urandom));
    send_byte(start_marker_q[15:8]);
    // kind < 8: start marker cut short after its first byte
    if (kind >= 8) begin
      send_byte(start_marker_q[7:0]);
      if (kind < 70) plen = $urandom_range(0, (lim > 12) ? 12 : lim - 1);
      else if (kind < 85) plen = lim - 1;
      else if (kind < 95) plen = lim + $urandom_range(0, 3);
      else plen = $urandom_range(0, 4);
      repeat (plen) send_byte(mdfr_pkg::BYTE_W'($urandom));
      if (kind < 95) begin
        send_byte(end_marker_q[15:8]);
        send_byte(end_marker_q[7:0]);
      end
    end
  endtask

  // reset markers: idle noise, a normal frame, then a frame holding only the end marker
  task automatic test_reset_markers();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_byte(8'hBC);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h34);
    send_byte(8'hDE);
    send_byte(8'h12);
    send_byte(8'hBC);
    send_byte(8'h34);
    send_byte(8'hDE);
    settle();
  endtask

  // limit of one: overflow abort, then the kept start window reopens a frame
  // on the next byte, which overflows again
  task automatic test_limit_and_carry();
    load_config(16'h0000, 16'hFFFF, 7'd1);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hAB);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();
  endtask

  task automatic test_single_byte_payload();
    load_config(16'hFFFF, 16'h0000, 7'd64);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h11);
    send_byte(8'h00);
    send_byte(8'h00);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    logic [mdfr_pkg::MAXPAY_W-1:0] maxp;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: maxp = 7'd64;
        1: maxp = 7'd1;
        2: maxp = mdfr_pkg::MAXPAY_W'($urandom_range(2, 8));
        default: maxp = mdfr_pkg::MAXPAY_W'($urandom_range(9, 64));
      endcase
      if (p == 3)
        load_config(mdfr_pkg::RESET_START_MARKER, mdfr_pkg::RESET_END_MARKER, maxp);
      else
        load_config(mdfr_pkg::MARKER_W'($urandom), mdfr_pkg::MARKER_W'($urandom), maxp);
      target = bytes_sent + RANDOM_PHASE_BYTES;
      while (bytes_sent < target) send_frame();
      settle();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mdfr_pkg::CFG_START_MARKER;
    cfg_data = '0;
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    start_marker_q = mdfr_pkg::RESET_START_MARKER;
    end_marker_q = mdfr_pkg::RESET_END_MARKER;
    max_payload_q = mdfr_pkg::RESET_MAX_PAYLOAD;
    scan_win = '0;
    tail_win = '0;
    in_frame_m = 1'b0;
    stored_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_markers();
    test_limit_and_carry();
    test_single_byte_payload();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("tb_marker_delimited_frame_receiver OK");
    else
      $display("tb_marker_delimited_frame_receiver NOT OK");
    $finish;
  end

endmodule
